// ===== rtl/core/tsef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsef_pkg
// Shared types and codes of the timestamped event queue: command modes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package tsef_pkg;

    localparam int EVT_KIND_W = 8;
    localparam int WORD_W     = 32;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_ENQ = 2'd0;
    localparam t_mode MODE_EXT = 2'd1;
    localparam t_mode MODE_QRY = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the beat and launch memory reads
        logic enq;       // store entry, bump counters
        logic ext;       // pop oldest entry
        logic query;     // report a counter
        logic set_ovf;   // enqueue hit a full queue
        logic finish;    // load result registers, raise strobe
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_mode mode;
        logic  kind_zero;
        logic  kind_in;
        logic  empty;
        logic  full;
        logic  ovf;
    } t_status;

endpackage

// ===== rtl/core/tsef_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsef_ctrl
// Two-state sequencer: accepts a beat, then decides and issues the
// datapath operation once the memory reads have landed.
// ----------------------------------------------------------------------------
module tsef_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tsef_pkg::t_status i_status,
    output tsef_pkg::t_cmd    o_cmd,
    output logic              busy
);

    tsef_pkg::t_state r_state;
    tsef_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsef_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            tsef_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = tsef_pkg::S_EXEC;
                end
            end
            tsef_pkg::S_EXEC: begin
                o_cmd.finish = 1'b1;
                n_state      = tsef_pkg::S_IDLE;
                // frozen after overflow: nothing changes
                if (!i_status.ovf) begin
                    unique case (i_status.mode)
                        tsef_pkg::MODE_ENQ: begin
                            if (i_status.kind_in && !i_status.kind_zero) begin
                                if (i_status.full) begin
                                    o_cmd.set_ovf = 1'b1;
                                end else begin
                                    o_cmd.enq = 1'b1;
                                end
                            end
                        end
                        tsef_pkg::MODE_EXT: begin
                            o_cmd.ext = !i_status.empty;
                        end
                        tsef_pkg::MODE_QRY: begin
                            o_cmd.query = i_status.kind_in;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = tsef_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state == tsef_pkg::S_EXEC);

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("exec state lasted more than one cycle");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.enq, o_cmd.ext, o_cmd.query, o_cmd.set_ovf}) <= 1)
        else $error("more than one datapath operation issued");

endmodule

// ===== rtl/core/tsef_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsef_dpath
// Entry ring memory, per-kind counter memory with valid bits, pointers,
// pending count, total counter, overflow flag and result registers.
// ----------------------------------------------------------------------------
module tsef_dpath #(
    parameter int QUEUE_DEPTH = 64,
    parameter int EVENT_KINDS = 16,
    localparam int PTR_W  = $clog2(QUEUE_DEPTH),
    localparam int PEND_W = $clog2(QUEUE_DEPTH + 1),
    localparam int KIND_W = $clog2(EVENT_KINDS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tsef_pkg::t_cmd                    i_cmd,
    input  tsef_pkg::t_mode                   i_mode,
    input  logic [tsef_pkg::EVT_KIND_W-1:0]   i_event_kind,
    input  logic [tsef_pkg::WORD_W-1:0]       i_event_data,
    input  logic [tsef_pkg::WORD_W-1:0]       i_now_us,
    output tsef_pkg::t_status                 o_status,
    output logic                              o_done,
    output logic [PEND_W-1:0]                 o_pending_count,
    output logic [tsef_pkg::EVT_KIND_W-1:0]   o_out_kind,
    output logic [tsef_pkg::WORD_W-1:0]       o_out_data,
    output logic [tsef_pkg::WORD_W-1:0]       o_out_stamp,
    output logic [tsef_pkg::WORD_W-1:0]       o_stat_value,
    output logic                              o_overflowed
);

    typedef struct packed {
        logic [tsef_pkg::EVT_KIND_W-1:0] kind;
        logic [tsef_pkg::WORD_W-1:0]     data;
        logic [tsef_pkg::WORD_W-1:0]     stamp;
    } t_entry;

    // captured beat
    tsef_pkg::t_mode                 r_mode;
    logic [tsef_pkg::EVT_KIND_W-1:0] r_kind;
    logic [tsef_pkg::WORD_W-1:0]     r_data;
    logic [tsef_pkg::WORD_W-1:0]     r_now;

    t_entry                          r_queue [QUEUE_DEPTH];
    t_entry                          r_q_rd;
    logic [tsef_pkg::WORD_W-1:0]     r_cnt_mem [EVENT_KINDS];
    logic [EVENT_KINDS-1:0]          r_cnt_vld;
    logic [tsef_pkg::WORD_W-1:0]     r_cnt_rd;
    logic                            r_cnt_rd_vld;

    logic [PTR_W-1:0]                r_rd_ptr;
    logic [PTR_W-1:0]                r_wr_ptr;
    logic [PEND_W-1:0]               r_pending;
    logic [tsef_pkg::WORD_W-1:0]     r_total;
    logic                            r_ovf;
    logic                            r_done;

    logic [PTR_W-1:0]                n_rd_ptr;
    logic [PTR_W-1:0]                n_wr_ptr;
    logic [tsef_pkg::WORD_W-1:0]     n_cnt;
    logic [tsef_pkg::WORD_W-1:0]     n_stat;
    logic [KIND_W-1:0]               w_rd_kind;
    logic [KIND_W-1:0]               w_wr_kind;

    assign n_rd_ptr  = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign n_wr_ptr  = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_kind = i_event_kind[KIND_W-1:0];
    assign w_wr_kind = r_kind[KIND_W-1:0];
    // a counter never written reads as zero
    assign n_cnt     = r_cnt_rd_vld ? r_cnt_rd + 1'b1 : tsef_pkg::WORD_W'(1);

    always_comb begin
        n_stat = '0;
        if (i_cmd.query) begin
            if (r_kind == '0) begin
                n_stat = r_total;
            end else if (r_cnt_rd_vld) begin
                n_stat = r_cnt_rd;
            end
        end
    end

    assign o_status.mode      = r_mode;
    assign o_status.kind_zero = (r_kind == '0);
    assign o_status.kind_in   = (9'(r_kind) < 9'(EVENT_KINDS));
    assign o_status.empty     = (r_pending == '0);
    assign o_status.full      = (r_pending == PEND_W'(QUEUE_DEPTH));
    assign o_status.ovf       = r_ovf;

    // beat capture and memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode       <= i_mode;
            r_kind       <= i_event_kind;
            r_data       <= i_event_data;
            r_now        <= i_now_us;
            r_q_rd       <= r_queue[r_rd_ptr];
            r_cnt_rd     <= r_cnt_mem[w_rd_kind];
            r_cnt_rd_vld <= r_cnt_vld[w_rd_kind];
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq) begin
            r_queue[r_wr_ptr]    <= '{kind: r_kind, data: r_data, stamp: r_now};
            r_cnt_mem[w_wr_kind] <= n_cnt;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_pending <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_cnt_vld <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.enq) begin
                r_wr_ptr             <= n_wr_ptr;
                r_pending            <= r_pending + 1'b1;
                r_total              <= r_total + 1'b1;
                r_cnt_vld[w_wr_kind] <= 1'b1;
            end else if (i_cmd.ext) begin
                r_rd_ptr  <= n_rd_ptr;
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_pending_count <= i_cmd.ext ? r_pending : '0;
            o_out_kind      <= i_cmd.ext ? r_q_rd.kind : '0;
            o_out_data      <= i_cmd.ext ? r_q_rd.data : '0;
            o_out_stamp     <= i_cmd.ext ? r_q_rd.stamp : '0;
            o_stat_value    <= n_stat;
            o_overflowed    <= r_ovf | i_cmd.set_ovf;
        end
    end

    assign o_done = r_done;

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(QUEUE_DEPTH))
        else $error("pending count beyond queue depth");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_no_enq_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enq |-> (r_pending != PEND_W'(QUEUE_DEPTH)) && !r_ovf)
        else $error("enqueue into full or frozen queue");

    a_frozen_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> !i_cmd.enq && !i_cmd.ext && !i_cmd.query)
        else $error("operation issued while frozen");

endmodule

// ===== rtl/core/timestamped_event_fifo_with_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_event_fifo_with_stats
// Timestamped event ring queue with per-kind enqueue counters.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low, and every beat yields
// exactly one result, shown for one cycle with o_done high; the receiver
// cannot stall it, so it must take each result in that cycle.
// Each beat passes through a capture step and an execute step (busy high
// in the second): the first launches the registered reads of the entry
// memory and the counter memory, the second updates pointers, counters and
// result registers. No new beat is taken while busy is high. No clearing pass
// after reset: counter valid bits reset at once. After an overflow the
// block is frozen until reset and answers only with o_overflowed set.
// ----------------------------------------------------------------------------
module timestamped_event_fifo_with_stats #(
    parameter int QUEUE_DEPTH = 64,
    parameter int EVENT_KINDS = 16,
    localparam int PEND_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_mode,
    input  logic [tsef_pkg::EVT_KIND_W-1:0] i_event_kind,
    input  logic [tsef_pkg::WORD_W-1:0]     i_event_data,
    input  logic [tsef_pkg::WORD_W-1:0]     i_now_us,
    output logic                            o_done,
    output logic [PEND_W-1:0]               o_pending_count,
    output logic [tsef_pkg::EVT_KIND_W-1:0] o_out_kind,
    output logic [tsef_pkg::WORD_W-1:0]     o_out_data,
    output logic [tsef_pkg::WORD_W-1:0]     o_out_stamp,
    output logic [tsef_pkg::WORD_W-1:0]     o_stat_value,
    output logic                            o_overflowed
);

    tsef_pkg::t_cmd    w_cmd;
    tsef_pkg::t_status w_status;

    tsef_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    tsef_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .EVENT_KINDS (EVENT_KINDS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_mode          (i_mode),
        .i_event_kind    (i_event_kind),
        .i_event_data    (i_event_data),
        .i_now_us        (i_now_us),
        .o_status        (w_status),
        .o_done          (o_done),
        .o_pending_count (o_pending_count),
        .o_out_kind      (o_out_kind),
        .o_out_data      (o_out_data),
        .o_out_stamp     (o_out_stamp),
        .o_stat_value    (o_stat_value),
        .o_overflowed    (o_overflowed)
    );

endmodule
